// File: sv/mbrtu_pkg.sv
// types, codes and crc helper shared by the modbus rtu read master blocks
`default_nettype none

package mbrtu_pkg;

    localparam logic       OP_REQUEST  = 1'b0;
    localparam logic       OP_RESPONSE = 1'b1;

    localparam logic [15:0] CRC_INIT   = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'hA001;
    localparam logic [9:0]  DATA_START = 10'd3;
    localparam logic [9:0]  INDEX_MAX  = 10'd1023;
    localparam logic [2:0]  CRC_BYTES  = 3'd6;
    localparam logic [2:0]  LAST_BYTE  = 3'd7;

    typedef enum logic
    {
        CMD_FRAME = 1'b0,
        CMD_VALUE = 1'b1
    } cmd_kind_t;

    typedef struct packed
    {
        logic        operation;
        logic [7:0]  device_address;
        logic [7:0]  func_code;
        logic [15:0] register_address;
        logic [7:0]  word_count;
        logic [7:0]  rx_byte;
        logic        rx_last;
    } item_t;

    typedef struct packed
    {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        value_valid;
        logic [31:0] value;
        logic        last;
    } result_t;

    typedef struct packed
    {
        cmd_kind_t   kind;
        logic [7:0]  device_address;
        logic [7:0]  func_code;
        logic [15:0] register_address;
        logic [7:0]  word_count;
        logic [31:0] value;
    } cmd_t;

    // one byte of crc-16/modbus, bitwise over eight steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[0])
            begin
                crc = (crc >> 1) ^ CRC_POLY;
            end
            else
            begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

`default_nettype wire

// File: sv/mbrtu_queue.sv
// command queue between the front and back parts
`default_nettype none

module mbrtu_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire mbrtu_pkg::cmd_t push_data,
    output logic                 full,
    input  wire logic            pop,
    output mbrtu_pkg::cmd_t      pop_data,
    output logic                 empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mbrtu_pkg::cmd_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: sv/mbrtu_front.sv
// front part: accepts items, tracks the response window and queues commands
`default_nettype none

module mbrtu_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire mbrtu_pkg::item_t item,
    output logic                  push,
    output mbrtu_pkg::cmd_t       push_data,
    input  wire logic             full
);

    logic [7:0]  expected_words_reg, expected_words_next;
    logic [9:0]  response_index_reg, response_index_next;
    logic [31:0] accumulator_reg, accumulator_next;

    logic        accept;
    logic [9:0]  window_end;
    logic [31:0] acc_upd;

    assign item_stall = full;
    assign accept     = item_valid && !full;
    assign window_end = mbrtu_pkg::DATA_START + {1'b0, expected_words_reg, 1'b0};

    always_comb
    begin
        expected_words_next = expected_words_reg;
        response_index_next = response_index_reg;
        accumulator_next    = accumulator_reg;
        push                = 1'b0;
        acc_upd             = accumulator_reg;

        push_data.kind             = mbrtu_pkg::CMD_FRAME;
        push_data.device_address   = item.device_address;
        push_data.func_code        = item.func_code;
        push_data.register_address = item.register_address;
        push_data.word_count       = item.word_count;
        push_data.value            = acc_upd;

        if (response_index_reg >= mbrtu_pkg::DATA_START && response_index_reg < window_end)
        begin
            acc_upd = {accumulator_reg[23:0], item.rx_byte};
        end

        if (accept)
        begin
            if (item.operation == mbrtu_pkg::OP_REQUEST)
            begin
                push                = 1'b1;
                expected_words_next = item.word_count;
                response_index_next = '0;
                accumulator_next    = '0;
            end
            else
            begin
                accumulator_next = acc_upd;
                if (response_index_reg != mbrtu_pkg::INDEX_MAX)
                begin
                    response_index_next = response_index_reg + 1'b1;
                end
                if (item.rx_last)
                begin
                    push                = 1'b1;
                    push_data.kind      = mbrtu_pkg::CMD_VALUE;
                    push_data.value     = acc_upd;
                    response_index_next = '0;
                    accumulator_next    = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words_reg <= '0;
            response_index_reg <= '0;
            accumulator_reg    <= '0;
        end
        else
        begin
            expected_words_reg <= expected_words_next;
            response_index_reg <= response_index_next;
            accumulator_reg    <= accumulator_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/mbrtu_back.sv
// back part: streams frame bytes with a running crc, or a collected value
`default_nettype none

module mbrtu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            empty,
    input  wire mbrtu_pkg::cmd_t pop_data,
    output logic                 pop,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output mbrtu_pkg::result_t   result
);

    logic               active_reg, active_next;
    logic [2:0]         byte_idx_reg, byte_idx_next;
    logic [15:0]        crc_reg, crc_next;
    mbrtu_pkg::cmd_t    frame_reg, frame_next;
    logic               out_valid_reg, out_valid_next;
    mbrtu_pkg::result_t out_reg, out_next;

    logic       advance;
    logic [7:0] cur_byte;

    assign advance      = !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        case (byte_idx_reg)
            3'd0:    cur_byte = frame_reg.device_address;
            3'd1:    cur_byte = frame_reg.func_code;
            3'd2:    cur_byte = frame_reg.register_address[15:8];
            3'd3:    cur_byte = frame_reg.register_address[7:0];
            3'd4:    cur_byte = 8'h00;
            3'd5:    cur_byte = frame_reg.word_count;
            3'd6:    cur_byte = crc_reg[7:0];
            default: cur_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        active_next    = active_reg;
        byte_idx_next  = byte_idx_reg;
        crc_next       = crc_reg;
        frame_next     = frame_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        pop            = 1'b0;

        if (advance)
        begin
            out_valid_next = 1'b0;
            if (active_reg)
            begin
                out_valid_next       = 1'b1;
                out_next.tx_valid    = 1'b1;
                out_next.tx_byte     = cur_byte;
                out_next.value_valid = 1'b0;
                out_next.value       = '0;
                out_next.last        = (byte_idx_reg == mbrtu_pkg::LAST_BYTE);
                if (byte_idx_reg < mbrtu_pkg::CRC_BYTES)
                begin
                    crc_next = mbrtu_pkg::crc_byte(crc_reg, cur_byte);
                end
                byte_idx_next = byte_idx_reg + 1'b1;
                if (byte_idx_reg == mbrtu_pkg::LAST_BYTE)
                begin
                    active_next = 1'b0;
                end
            end
            else if (!empty)
            begin
                pop            = 1'b1;
                out_valid_next = 1'b1;
                if (pop_data.kind == mbrtu_pkg::CMD_VALUE)
                begin
                    out_next.tx_valid    = 1'b0;
                    out_next.tx_byte     = '0;
                    out_next.value_valid = 1'b1;
                    out_next.value       = pop_data.value;
                    out_next.last        = 1'b1;
                end
                else
                begin
                    // byte 0 goes out right away, crc starts on it
                    frame_next           = pop_data;
                    crc_next             = mbrtu_pkg::crc_byte(mbrtu_pkg::CRC_INIT,
                                                               pop_data.device_address);
                    byte_idx_next        = 3'd1;
                    active_next          = 1'b1;
                    out_next.tx_valid    = 1'b1;
                    out_next.tx_byte     = pop_data.device_address;
                    out_next.value_valid = 1'b0;
                    out_next.value       = '0;
                    out_next.last        = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            byte_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            byte_idx_reg  <= byte_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg   <= crc_next;
        frame_reg <= frame_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire

// File: sv/modbus_rtu_read_master_frames_top.sv
// top level of the modbus rtu read master framer and response collector
// A request item (operation 0) produces eight result items: the read frame
// bytes followed by the crc-16/modbus low and high bytes, one per cycle unless
// result_stall holds the result register; the back sequencer folds one byte per
// cycle into the running crc under the same condition. Response bytes
// (operation 1) are taken one per cycle while the queue is not full; only
// the byte marked last yields a result, the value collected big-endian from
// the data window, emitted as a single result item. Input is stalled only
// while the command queue (QUEUE_DEPTH entries) is full, and a result
// register sits in front of the result port. Response crc is not checked.
`default_nettype none

module modbus_rtu_read_master_frames_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             item_valid,
    output logic                  item_stall,
    input  wire mbrtu_pkg::item_t item,
    output logic                  result_valid,
    input  wire logic             result_stall,
    output mbrtu_pkg::result_t    result
);

    logic            push;
    mbrtu_pkg::cmd_t push_data;
    logic            full;
    logic            pop;
    mbrtu_pkg::cmd_t pop_data;
    logic            empty;

    mbrtu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .push       (push),
        .push_data  (push_data),
        .full       (full)
    );

    mbrtu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    mbrtu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

`default_nettype wire
